// ----- hw/rtl/ecbu_pkg.sv -----
package ecbu_pkg;

    // number formats
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int VEC_FRAC_BITS   = 14;
    localparam int CORDIC_ITERS    = 16;
    localparam int DEG_FRAC        = 16;
    localparam int ANG_SHIFT       = DEG_FRAC - ANGLE_FRAC_BITS;
    localparam int INNER           = 30;

    localparam int HALF_TURN  = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN  = 360 << ANGLE_FRAC_BITS;
    localparam int PITCH_LIM  = 89 << ANGLE_FRAC_BITS;
    localparam int WRAP_STEPS = 8;
    localparam int WRAP_W     = 24;

    localparam int Q90       = 90 << DEG_FRAC;
    localparam int Q180      = 180 << DEG_FRAC;
    localparam int CORDIC_X0 = 652032874;

    localparam int VEC_ONE    = 1 << VEC_FRAC_BITS;
    localparam int SQRT_STEPS = 31;
    localparam int LEN_W      = 31;
    localparam int QUOT_W     = 17;
    localparam int NUM_W      = INNER + VEC_FRAC_BITS + 1;
    localparam int XMUL_STEPS = 7;
    localparam int SQ_STEPS   = 4;
    localparam int CNT_W      = 5;

    localparam logic signed [15:0] RESET_YAW   = -16'sd11520;
    localparam logic signed [15:0] RESET_PITCH = 16'sd0;

    // register map
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_SENS        = 3'd0;
    localparam t_reg_idx REG_CLAMP       = 3'd1;
    localparam t_reg_idx REG_UP_X        = 3'd2;
    localparam t_reg_idx REG_UP_Y        = 3'd3;
    localparam t_reg_idx REG_UP_Z        = 3'd4;
    localparam t_reg_idx REG_START_YAW   = 3'd5;
    localparam t_reg_idx REG_START_PITCH = 3'd6;

    // datapath operations
    typedef logic [4:0] t_op;
    localparam t_op OP_NONE  = 5'd0;
    localparam t_op OP_LOAD  = 5'd1;
    localparam t_op OP_MDX   = 5'd2;
    localparam t_op OP_MDY   = 5'd3;
    localparam t_op OP_SUMP  = 5'd4;
    localparam t_op OP_WRAP  = 5'd5;
    localparam t_op OP_ANG   = 5'd6;
    localparam t_op OP_CINIT = 5'd7;
    localparam t_op OP_CORD  = 5'd8;
    localparam t_op OP_CEND  = 5'd9;
    localparam t_op OP_FX    = 5'd10;
    localparam t_op OP_FZ    = 5'd11;
    localparam t_op OP_FV    = 5'd12;
    localparam t_op OP_XMUL  = 5'd13;
    localparam t_op OP_SHIFT = 5'd14;
    localparam t_op OP_DEGEN = 5'd15;
    localparam t_op OP_SQ    = 5'd16;
    localparam t_op OP_SQRT  = 5'd17;
    localparam t_op OP_DINIT = 5'd18;
    localparam t_op OP_DIV   = 5'd19;
    localparam t_op OP_DEND  = 5'd20;
    localparam t_op OP_OUT   = 5'd21;

    typedef struct packed {
        logic [15:0]        sensitivity;
        logic               clamp_pitch;
        logic signed [15:0] world_up_x;
        logic signed [15:0] world_up_y;
        logic signed [15:0] world_up_z;
        logic signed [15:0] start_yaw;
        logic signed [14:0] start_pitch;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] idx;
        logic             xsel;
    } t_cmd;

    typedef struct packed {
        logic vec_zero;
        logic need_shift;
    } t_stat;

    // arctangent of 2^-i in 1/65536 degree
    function automatic logic signed [24:0] atan_at(input logic [CNT_W-1:0] i);
        case (i)
            5'd0:    return 25'sd2949120;
            5'd1:    return 25'sd1740967;
            5'd2:    return 25'sd919879;
            5'd3:    return 25'sd466945;
            5'd4:    return 25'sd234379;
            5'd5:    return 25'sd117304;
            5'd6:    return 25'sd58666;
            5'd7:    return 25'sd29335;
            5'd8:    return 25'sd14668;
            5'd9:    return 25'sd7334;
            5'd10:   return 25'sd3667;
            5'd11:   return 25'sd1833;
            5'd12:   return 25'sd917;
            5'd13:   return 25'sd458;
            5'd14:   return 25'sd229;
            5'd15:   return 25'sd115;
            5'd16:   return 25'sd57;
            5'd17:   return 25'sd29;
            5'd18:   return 25'sd14;
            5'd19:   return 25'sd7;
            5'd20:   return 25'sd4;
            5'd21:   return 25'sd2;
            5'd22:   return 25'sd1;
            default: return 25'sd0;
        endcase
    endfunction

endpackage

// ----- hw/rtl/ecbu_regs.sv -----
module ecbu_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output ecbu_pkg::t_cfg   o_cfg
);
    import ecbu_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensitivity <= 16'd6554;
            r_cfg.clamp_pitch <= 1'b1;
            r_cfg.world_up_x  <= 16'sd0;
            r_cfg.world_up_y  <= 16'sd16384;
            r_cfg.world_up_z  <= 16'sd0;
            r_cfg.start_yaw   <= RESET_YAW;
            r_cfg.start_pitch <= 15'sd0;
        end else if (wr) begin
            case (idx)
                REG_SENS:        r_cfg.sensitivity <= pwdata[15:0];
                REG_CLAMP:       r_cfg.clamp_pitch <= pwdata[0];
                REG_UP_X:        r_cfg.world_up_x  <= pwdata[15:0];
                REG_UP_Y:        r_cfg.world_up_y  <= pwdata[15:0];
                REG_UP_Z:        r_cfg.world_up_z  <= pwdata[15:0];
                REG_START_YAW:   r_cfg.start_yaw   <= pwdata[15:0];
                REG_START_PITCH: r_cfg.start_pitch <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SENS:        prdata = {16'b0, r_cfg.sensitivity};
            REG_CLAMP:       prdata = {31'b0, r_cfg.clamp_pitch};
            REG_UP_X:        prdata = {16'b0, r_cfg.world_up_x};
            REG_UP_Y:        prdata = {16'b0, r_cfg.world_up_y};
            REG_UP_Z:        prdata = {16'b0, r_cfg.world_up_z};
            REG_START_YAW:   prdata = {16'b0, r_cfg.start_yaw};
            REG_START_PITCH: prdata = {17'b0, r_cfg.start_pitch};
            default:         prdata = 32'b0;
        endcase
    end

endmodule

// ----- hw/rtl/ecbu_ctrl.sv -----
module ecbu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ecbu_pkg::t_stat i_stat,
    output ecbu_pkg::t_cmd  o_cmd
);
    import ecbu_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MDX   = 5'd1;
    localparam logic [4:0] ST_MDY   = 5'd2;
    localparam logic [4:0] ST_SUMP  = 5'd3;
    localparam logic [4:0] ST_WRAP  = 5'd4;
    localparam logic [4:0] ST_ANG   = 5'd5;
    localparam logic [4:0] ST_CINIT = 5'd6;
    localparam logic [4:0] ST_CORD  = 5'd7;
    localparam logic [4:0] ST_CEND  = 5'd8;
    localparam logic [4:0] ST_FX    = 5'd9;
    localparam logic [4:0] ST_FZ    = 5'd10;
    localparam logic [4:0] ST_FV    = 5'd11;
    localparam logic [4:0] ST_XMUL  = 5'd12;
    localparam logic [4:0] ST_NORM  = 5'd13;
    localparam logic [4:0] ST_SQ    = 5'd14;
    localparam logic [4:0] ST_SQRT  = 5'd15;
    localparam logic [4:0] ST_DINIT = 5'd16;
    localparam logic [4:0] ST_DIV   = 5'd17;
    localparam logic [4:0] ST_DEND  = 5'd18;
    localparam logic [4:0] ST_OUT   = 5'd19;

    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_sel, n_sel;
    logic             r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_sel    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sel      = r_sel;
        n_ovalid   = r_ovalid && !i_out_ready;
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = r_cnt;
        o_cmd.xsel = r_sel;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MDX;
                end
            end
            ST_MDX: begin
                o_cmd.op = OP_MDX;
                n_state  = ST_MDY;
            end
            ST_MDY: begin
                o_cmd.op = OP_MDY;
                n_state  = ST_SUMP;
            end
            ST_SUMP: begin
                o_cmd.op = OP_SUMP;
                n_cnt    = CNT_W'(WRAP_STEPS - 1);
                n_state  = ST_WRAP;
            end
            ST_WRAP: begin
                o_cmd.op = OP_WRAP;
                if (r_cnt == '0) begin
                    n_state = ST_ANG;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_ANG: begin
                o_cmd.op = OP_ANG;
                n_state  = ST_CINIT;
            end
            ST_CINIT: begin
                o_cmd.op = OP_CINIT;
                n_cnt    = '0;
                n_state  = ST_CORD;
            end
            ST_CORD: begin
                o_cmd.op = OP_CORD;
                if (r_cnt == CNT_W'(CORDIC_ITERS - 1)) begin
                    n_state = ST_CEND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CEND: begin
                o_cmd.op = OP_CEND;
                n_state  = ST_FX;
            end
            ST_FX: begin
                o_cmd.op = OP_FX;
                n_state  = ST_FZ;
            end
            ST_FZ: begin
                o_cmd.op = OP_FZ;
                n_state  = ST_FV;
            end
            ST_FV: begin
                o_cmd.op = OP_FV;
                n_sel    = 1'b0;
                n_cnt    = '0;
                n_state  = ST_XMUL;
            end
            ST_XMUL: begin
                o_cmd.op = OP_XMUL;
                if (r_cnt == CNT_W'(XMUL_STEPS - 1)) begin
                    n_state = ST_NORM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_NORM: begin
                if (i_stat.vec_zero) begin
                    o_cmd.op = OP_DEGEN;
                    n_state  = ST_OUT;
                end else if (i_stat.need_shift) begin
                    o_cmd.op = OP_SHIFT;
                end else begin
                    n_cnt   = '0;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.op = OP_SQ;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_DINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    n_state = ST_DEND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DEND: begin
                o_cmd.op = OP_DEND;
                if (r_sel) begin
                    n_state = ST_OUT;
                end else begin
                    n_sel   = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_XMUL;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/ecbu_dp.sv -----
module ecbu_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecbu_pkg::t_cfg     i_cfg,
    input  ecbu_pkg::t_cmd     i_cmd,
    output ecbu_pkg::t_stat    o_stat,
    input  logic               i_action,
    input  logic signed [15:0] i_mouse_dx,
    input  logic signed [15:0] i_mouse_dy,
    output logic signed [15:0] o_front_x,
    output logic signed [15:0] o_front_y,
    output logic signed [15:0] o_front_z,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_up_x,
    output logic signed [15:0] o_up_y,
    output logic signed [15:0] o_up_z,
    output logic signed [15:0] o_yaw_out,
    output logic signed [15:0] o_pitch_out,
    output logic               o_degenerate
);
    import ecbu_pkg::*;

    localparam logic signed [24:0] HALF_S  = 25'(HALF_TURN);
    localparam logic signed [24:0] WRAP_UP = 25'(FULL_TURN << (WRAP_STEPS - 1));
    localparam logic signed [24:0] P_LIM   = 25'(PITCH_LIM);
    localparam logic signed [24:0] Z90     = 25'(Q90);
    localparam logic signed [24:0] Z180    = 25'(Q180);
    localparam logic signed [63:0] RND_ANG = 64'(1 << (ANG_SHIFT - 1));
    localparam logic signed [33:0] RND_VEC = 34'(1 << (INNER - VEC_FRAC_BITS - 1));
    localparam logic signed [33:0] ONE_S   = 34'(VEC_ONE);

    // Q30 value -> vector format, half up, saturated
    function automatic logic signed [15:0] round_vec(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + RND_VEC) >>> (INNER - VEC_FRAC_BITS);
        if (r > ONE_S) return 16'(VEC_ONE);
        if (r < -ONE_S) return -16'(VEC_ONE);
        return 16'(r);
    endfunction

    // offset into 0..FULL_TURN*2^k range before the subtract ladder
    function automatic logic [WRAP_W-1:0] wrap_prep(input logic signed [24:0] s);
        logic signed [24:0] t;
        t = s + HALF_S;
        if (t < 0) t = t + WRAP_UP;
        return t[WRAP_W-1:0];
    endfunction

    // item and angle state
    logic               r_act;
    logic signed [15:0] r_dx, r_dy;
    logic signed [15:0] r_yaw, r_pitch;
    logic [WRAP_W-1:0]  r_wy, r_wp;
    logic signed [24:0] r_pv;

    // CORDIC lanes: 0 yaw, 1 pitch
    logic signed [31:0] r_x [2];
    logic signed [31:0] r_y [2];
    logic signed [24:0] r_z [2];
    logic               r_neg [2];

    // shared multiplier
    logic signed [31:0] m_a, m_b;
    logic signed [63:0] r_prod;

    // vectors
    logic signed [15:0] r_f [3];
    logic signed [15:0] r_r [3];
    logic signed [15:0] r_u [3];
    logic signed [15:0] w [3];
    logic signed [15:0] xa [3];
    logic signed [15:0] xb [3];
    logic signed [31:0] r_c [3];
    logic [31:0]        c_mag [3];
    logic               r_deg;

    // square root and divide
    logic [61:0]         r_ssq;
    logic [32:0]         r_srem;
    logic [LEN_W-1:0]    r_root;
    logic [34:0]         s_rem2, s_trial;
    logic [31:0]         r_drem [3];
    logic [QUOT_W-1:0]   r_dq [3];

    logic signed [24:0] a_rnd;
    logic signed [24:0] s_sum;
    logic [4:0]         kk;

    assign w[0] = i_cfg.world_up_x;
    assign w[1] = i_cfg.world_up_y;
    assign w[2] = i_cfg.world_up_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xa[i]    = i_cmd.xsel ? r_r[i] : r_f[i];
            xb[i]    = i_cmd.xsel ? r_f[i] : w[i];
            c_mag[i] = r_c[i][31] ? 32'(-r_c[i]) : 32'(r_c[i]);
        end
        o_stat.vec_zero   = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        o_stat.need_shift = (c_mag[0][31:28] == '0) && (c_mag[1][31:28] == '0)
                            && (c_mag[2][31:28] == '0);
    end

    // rounded scaled delta from the previous product
    assign a_rnd = 25'((r_prod + RND_ANG) >>> ANG_SHIFT);
    assign kk    = i_cmd.idx - 1'b1;

    always_comb begin
        s_sum = '0;
        if (i_cmd.op == OP_MDY) begin
            s_sum = r_act ? 25'(i_cfg.start_yaw) : 25'(r_yaw) + a_rnd;
        end else begin
            s_sum = r_act ? 25'(i_cfg.start_pitch) : 25'(r_pitch) + a_rnd;
        end
        s_rem2  = {r_srem, r_ssq[61:60]};
        s_trial = {2'b0, r_root, 2'b01};
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_MDX: begin
                m_a = 32'(r_dx);
                m_b = $signed({16'b0, i_cfg.sensitivity});
            end
            OP_MDY: begin
                m_a = 32'(r_dy);
                m_b = $signed({16'b0, i_cfg.sensitivity});
            end
            OP_FX: begin
                m_a = r_x[0];
                m_b = r_x[1];
            end
            OP_FZ: begin
                m_a = r_y[0];
                m_b = r_x[1];
            end
            OP_XMUL: begin
                case (i_cmd.idx)
                    5'd0: begin m_a = 32'(xa[1]); m_b = 32'(xb[2]); end
                    5'd1: begin m_a = 32'(xa[2]); m_b = 32'(xb[1]); end
                    5'd2: begin m_a = 32'(xa[2]); m_b = 32'(xb[0]); end
                    5'd3: begin m_a = 32'(xa[0]); m_b = 32'(xb[2]); end
                    5'd4: begin m_a = 32'(xa[0]); m_b = 32'(xb[1]); end
                    5'd5: begin m_a = 32'(xa[1]); m_b = 32'(xb[0]); end
                    default: ;
                endcase
            end
            OP_SQ: begin
                if (i_cmd.idx < 5'd3) begin
                    m_a = r_c[i_cmd.idx[1:0]];
                    m_b = r_c[i_cmd.idx[1:0]];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= RESET_YAW;
            r_pitch <= RESET_PITCH;
        end else if (i_cmd.op == OP_ANG) begin
            r_yaw <= 16'(r_wy - WRAP_W'(HALF_TURN));
            if (i_cfg.clamp_pitch) begin
                if (r_pv > P_LIM) begin
                    r_pitch <= 16'(P_LIM);
                end else if (r_pv < -P_LIM) begin
                    r_pitch <= 16'(-P_LIM);
                end else begin
                    r_pitch <= 16'(r_pv);
                end
            end else begin
                r_pitch <= 16'(r_wp - WRAP_W'(HALF_TURN));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_act <= i_action;
                r_dx  <= i_mouse_dx;
                r_dy  <= i_mouse_dy;
                r_deg <= 1'b0;
            end
            OP_MDY: r_wy <= wrap_prep(s_sum);
            OP_SUMP: begin
                r_pv <= s_sum;
                r_wp <= wrap_prep(s_sum);
            end
            OP_WRAP: begin
                if (r_wy >= (WRAP_W'(FULL_TURN) << i_cmd.idx[2:0])) begin
                    r_wy <= r_wy - (WRAP_W'(FULL_TURN) << i_cmd.idx[2:0]);
                end
                if (r_wp >= (WRAP_W'(FULL_TURN) << i_cmd.idx[2:0])) begin
                    r_wp <= r_wp - (WRAP_W'(FULL_TURN) << i_cmd.idx[2:0]);
                end
            end
            OP_CINIT: begin
                for (int l = 0; l < 2; l++) begin
                    logic signed [24:0] za;
                    za = (l == 0) ? (25'(r_yaw) <<< ANG_SHIFT)
                                  : (25'(r_pitch) <<< ANG_SHIFT);
                    r_x[l] <= 32'(CORDIC_X0);
                    r_y[l] <= '0;
                    if (za > Z90) begin
                        r_z[l]   <= za - Z180;
                        r_neg[l] <= 1'b1;
                    end else if (za < -Z90) begin
                        r_z[l]   <= za + Z180;
                        r_neg[l] <= 1'b1;
                    end else begin
                        r_z[l]   <= za;
                        r_neg[l] <= 1'b0;
                    end
                end
            end
            OP_CORD: begin
                for (int l = 0; l < 2; l++) begin
                    if (!r_z[l][24]) begin
                        r_x[l] <= r_x[l] - (r_y[l] >>> i_cmd.idx);
                        r_y[l] <= r_y[l] + (r_x[l] >>> i_cmd.idx);
                        r_z[l] <= r_z[l] - atan_at(i_cmd.idx);
                    end else begin
                        r_x[l] <= r_x[l] + (r_y[l] >>> i_cmd.idx);
                        r_y[l] <= r_y[l] - (r_x[l] >>> i_cmd.idx);
                        r_z[l] <= r_z[l] + atan_at(i_cmd.idx);
                    end
                end
            end
            OP_CEND: begin
                for (int l = 0; l < 2; l++) begin
                    if (r_neg[l]) begin
                        r_x[l] <= -r_x[l];
                        r_y[l] <= -r_y[l];
                    end
                end
            end
            OP_FZ: r_f[0] <= round_vec(34'(r_prod >>> INNER));
            OP_FV: begin
                r_f[2] <= round_vec(34'(r_prod >>> INNER));
                r_f[1] <= round_vec(34'(r_y[1]));
            end
            OP_XMUL: begin
                if (i_cmd.idx != '0) begin
                    if (!kk[0]) begin
                        r_c[kk[2:1]] <= r_prod[31:0];
                    end else begin
                        r_c[kk[2:1]] <= r_c[kk[2:1]] - r_prod[31:0];
                    end
                end
            end
            OP_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    r_c[i] <= r_c[i] <<< 1;
                end
            end
            OP_DEGEN: begin
                r_deg <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_r[i] <= '0;
                    r_u[i] <= '0;
                end
            end
            OP_SQ: begin
                if (i_cmd.idx == 5'd0) begin
                    r_srem <= '0;
                    r_root <= '0;
                end else if (i_cmd.idx == 5'd1) begin
                    r_ssq <= r_prod[61:0];
                end else begin
                    r_ssq <= r_ssq + r_prod[61:0];
                end
            end
            OP_SQRT: begin
                r_ssq <= {r_ssq[59:0], 2'b00};
                if (s_rem2 >= s_trial) begin
                    r_srem <= 33'(s_rem2 - s_trial);
                    r_root <= {r_root[LEN_W-2:0], 1'b1};
                end else begin
                    r_srem <= s_rem2[32:0];
                    r_root <= {r_root[LEN_W-2:0], 1'b0};
                end
            end
            OP_DINIT: begin
                for (int i = 0; i < 3; i++) begin
                    logic [NUM_W-1:0] num;
                    num = {1'b0, c_mag[i][INNER-1:0], VEC_FRAC_BITS'(0)}
                          + NUM_W'(r_root >> 1);
                    r_drem[i] <= 32'(num[NUM_W-1:QUOT_W]);
                    r_dq[i]   <= num[QUOT_W-1:0];
                end
            end
            OP_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    logic [32:0] t;
                    t = {r_drem[i], r_dq[i][QUOT_W-1]};
                    if (t >= {2'b0, r_root}) begin
                        r_drem[i] <= 32'(t - {2'b0, r_root});
                        r_dq[i]   <= {r_dq[i][QUOT_W-2:0], 1'b1};
                    end else begin
                        r_drem[i] <= t[31:0];
                        r_dq[i]   <= {r_dq[i][QUOT_W-2:0], 1'b0};
                    end
                end
            end
            OP_DEND: begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [15:0] v;
                    v = (r_dq[i] > QUOT_W'(VEC_ONE)) ? 16'(VEC_ONE) : 16'(r_dq[i]);
                    if (r_c[i][31]) v = -v;
                    if (i_cmd.xsel) r_u[i] <= v;
                    else            r_r[i] <= v;
                end
            end
            OP_OUT: begin
                o_front_x    <= r_f[0];
                o_front_y    <= r_f[1];
                o_front_z    <= r_f[2];
                o_right_x    <= r_r[0];
                o_right_y    <= r_r[1];
                o_right_z    <= r_r[2];
                o_up_x       <= r_u[0];
                o_up_y       <= r_u[1];
                o_up_z       <= r_u[2];
                o_yaw_out    <= r_yaw;
                o_pitch_out  <= r_pitch;
                o_degenerate <= r_deg;
            end
            default: ;
        endcase
    end

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_ANG |=> (r_yaw >= -16'sd23040) && (r_yaw <= 16'sd23039))
        else $error("yaw left the wrapped range");

    a_pitch_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ANG) && i_cfg.clamp_pitch
        |=> (r_pitch <= 16'sd11392) && (r_pitch >= -16'sd11392))
        else $error("pitch not clamped");

    a_unit_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DEND) && !i_cmd.xsel
        |=> (r_r[0] <= 16'sd16384) && (r_r[0] >= -16'sd16384)
            && (r_r[1] <= 16'sd16384) && (r_r[1] >= -16'sd16384)
            && (r_r[2] <= 16'sd16384) && (r_r[2] >= -16'sd16384))
        else $error("normalized component beyond one");

endmodule

// ----- hw/rtl/euler_camera_basis_update.sv -----
// Camera look-vector unit. Each input beat either applies a mouse delta pair
// (action 0) or reloads yaw and pitch from the start registers (action 1),
// and produces one result beat: front, right and up in Q1.14, the new yaw and
// pitch in 1/128 degree, and a degenerate flag when a cross product is zero.
//
// Input channel i_valid/o_ready, output channel o_valid/i_ready. o_ready is
// high only while the sequencer is idle; one item is worked at a time.
// The sequencer runs 8 wrap steps, 16 CORDIC iterations, then two normalize
// passes (cross product, normalize shifts up to 28 per pass, 4-step sum of
// squares, 31-step square root, 17-step divide). A zero right cross product
// ends the item early. The next beat is taken in the cycle after the result
// register loads.
//
// The finished result sits in an output register; the next item is accepted
// while it waits, and the sequencer holds before loading the register until
// the receiver takes the previous beat.
//
// Reset (synchronous, active low) restores the registers to defaults and
// sets yaw to -90 degrees and pitch to 0. The user must write registers over
// the APB port only while no item is in flight; the block does not enforce it.
module euler_camera_basis_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input beat
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic signed [15:0] i_mouse_dx,
    input  logic signed [15:0] i_mouse_dy,
    // result beat
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_front_x,
    output logic signed [15:0] o_front_y,
    output logic signed [15:0] o_front_z,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_up_x,
    output logic signed [15:0] o_up_y,
    output logic signed [15:0] o_up_z,
    output logic signed [15:0] o_yaw_out,
    output logic signed [15:0] o_pitch_out,
    output logic               o_degenerate
);
    import ecbu_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    // register file
    ecbu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: walks angle update, CORDIC, cross and normalize passes
    ecbu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // angle state, CORDIC lanes, shared multiplier, sqrt and divide
    ecbu_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_mouse_dx   (i_mouse_dx),
        .i_mouse_dy   (i_mouse_dy),
        .o_front_x    (o_front_x),
        .o_front_y    (o_front_y),
        .o_front_z    (o_front_z),
        .o_right_x    (o_right_x),
        .o_right_y    (o_right_y),
        .o_right_z    (o_right_z),
        .o_up_x       (o_up_x),
        .o_up_y       (o_up_y),
        .o_up_z       (o_up_z),
        .o_yaw_out    (o_yaw_out),
        .o_pitch_out  (o_pitch_out),
        .o_degenerate (o_degenerate)
    );

endmodule
